/* design/gvr_pkg.sv */
// ----------------------------------------------------------------------------
// GARCH volatility recursion package
// Shared widths, reset values, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package gvr_pkg;

   // Field widths.
   localparam int Z_W        = 16;   // innovation, signed Q3.12
   localparam int SHOCK_W    = 20;   // shock, signed Q7.12
   localparam int VAR_W      = 24;   // variance, unsigned Q8.16
   localparam int WGT_W      = 16;   // weights, unsigned Q0.16
   localparam int WARM_W     = 16;   // warm-up counters
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Model orders and history depth.
   localparam int ARCH_ORDER  = 3;
   localparam int GARCH_ORDER = 3;
   localparam int HIST_DEPTH  = 3;
   localparam int HIST_IDX_W  = 2;

   // Serial multiplier: one multiplier bit per cycle.
   localparam int MAC_W      = 20;
   localparam int MAC_STEPS  = MAC_W;
   localparam int MAC_CNT_W  = $clog2(MAC_STEPS);
   localparam int PROD_W     = 56;
   localparam int SQ_W       = 2 * SHOCK_W;

   // Variance accumulator in units of 2^-40.
   localparam int ACC_W            = 58;
   localparam int VAR_ROUND_SHIFT  = 24;
   localparam int GARCH_ALIGN      = 8;

   // Serial square root: one root bit per cycle.
   localparam int ROOT_W     = 20;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 2;
   localparam int SQRT_CNT_W = $clog2(ROOT_W);
   localparam int VOL_SHIFT  = RAD_W - VAR_W;

   // Shock rounding from units of 2^-28 to 2^-12.
   localparam int SHOCK_ROUND_SHIFT = 16;
   localparam int MAG_W             = PROD_W - SHOCK_ROUND_SHIFT;

   localparam logic [CSR_DATA_W-1:0] BASE_VARIANCE_RESET = 24'd6554;
   localparam logic [VAR_W-1:0]      VAR_ONE             = 24'd65536;
   localparam logic [VAR_W-1:0]      VAR_MAX             = 24'hFFFFFF;
   localparam logic [MAG_W-1:0]      MAG_POS_LIMIT       = MAG_W'(524287);
   localparam logic [MAG_W-1:0]      MAG_NEG_LIMIT       = MAG_W'(524288);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_VARIANCE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARCH_WEIGHT_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ARCH_WEIGHT_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ARCH_WEIGHT_3 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GARCH_WEIGHT_1 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GARCH_WEIGHT_2 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GARCH_WEIGHT_3 = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_START,
      ST_SQ_WAIT,
      ST_AW_START,
      ST_AW_WAIT,
      ST_GW_START,
      ST_GW_WAIT,
      ST_ROUND,
      ST_SQRT_START,
      ST_SQRT_WAIT,
      ST_SHOCK_START,
      ST_SHOCK_WAIT,
      ST_FINISH
   } seq_state_type;

   // Handshake between the sequencer and a serial arithmetic unit.
   typedef struct packed {
      logic start;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

/* design/gvr_mac.sv */
// ----------------------------------------------------------------------------
// GVR serial multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gvr_mac import gvr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  unit_cmd_type          cmd,
   input  logic [PROD_W-1:0]     mcand,
   input  logic [MAC_W-1:0]      mplier,
   output unit_status_type       status,
   output logic [PROD_W-1:0]     product
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MAC_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]    mcand_ff, mcand_in;
   logic [MAC_W-1:0]     mplier_ff, mplier_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = mcand;
         mplier_in = mplier;
         prod_in   = '0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + MAC_CNT_W'(1);
         if (cnt_ff == MAC_CNT_W'(MAC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = prod_ff;

endmodule

`default_nettype wire

/* design/gvr_sqrt.sv */
// ----------------------------------------------------------------------------
// GVR serial square root
// Restoring integer square root that settles one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gvr_sqrt import gvr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  unit_cmd_type          cmd,
   input  logic [RAD_W-1:0]      radicand,
   output unit_status_type       status,
   output logic [ROOT_W-1:0]     root
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [REM_W+1:0]      partial;
   logic [REM_W+1:0]      trial;

   // Two radicand bits enter the remainder each step; the trial is 4*root + 1.
   assign partial = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (partial >= trial) begin
            rem_in  = REM_W'(partial - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = partial[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + SQRT_CNT_W'(1);
         if (cnt_ff == SQRT_CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

`default_nettype wire

/* design/garch_volatility_recursion.sv */
// ----------------------------------------------------------------------------
// GARCH volatility recursion
// Sequencer, history and output register around a serial multiplier and a
// serial square root that form the conditional variance and the shock.
// ----------------------------------------------------------------------------
// Each input word is worked through before the next one is taken: ten passes of
// the one shared bit-serial multiplier, a serial square root, a rounding state,
// a commit state that waits for the output register to take the word, and the
// idle state that takes the word.
// Reset: synchronous; shock history clears to zero, variance history to one,
// the warm-up count to zero and the registers to their defaults.
`default_nettype none

module garch_volatility_recursion import gvr_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [Z_W-1:0]        req_innovation,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [SHOCK_W-1:0]    rsp_shock,
   output logic [VAR_W-1:0]             rsp_variance,
   output logic                         rsp_saturated,
   input  logic                         csr_write_enable,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data
);

   localparam logic [HIST_IDX_W-1:0] LAST_TERM = HIST_IDX_W'(HIST_DEPTH - 1);
   localparam logic [ACC_W-1:0] VAR_ROUND_BIAS = ACC_W'(1) << (VAR_ROUND_SHIFT - 1);
   localparam logic [PROD_W-1:0] SHOCK_ROUND_BIAS =
      PROD_W'(1) << (SHOCK_ROUND_SHIFT - 1);

   seq_state_type state_ff, state_in;
   logic [HIST_IDX_W-1:0] term_ff, term_in;

   // Configuration registers.
   logic [VAR_W-1:0]  base_variance_ff;
   logic [WARM_W-1:0] warmup_count_ff;
   logic [WGT_W-1:0]  arch_w_ff  [HIST_DEPTH];
   logic [WGT_W-1:0]  garch_w_ff [HIST_DEPTH];

   // Recursion state.
   logic [SHOCK_W-1:0] shock_hist_ff [HIST_DEPTH];
   logic [VAR_W-1:0]   var_hist_ff   [HIST_DEPTH];
   logic [WARM_W-1:0]  warmup_done_ff;

   // Per-word working registers.
   logic [Z_W-1:0]     z_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [VAR_W-1:0]   var_ff;
   logic [ROOT_W-1:0]  vol_ff;
   logic [SHOCK_W-1:0] shock_ff;
   logic               sat_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SHOCK_W-1:0] rsp_shock_ff;
   logic [VAR_W-1:0]   rsp_variance_ff;
   logic               rsp_saturated_ff;

   unit_cmd_type      mac_cmd, sqrt_cmd;
   unit_status_type   mac_status, sqrt_status;
   logic [PROD_W-1:0] mac_mcand, mac_product;
   logic [MAC_W-1:0]  mac_mplier;
   logic [ROOT_W-1:0] sqrt_root;

   logic               finish_go;
   logic               suppress;
   logic [SHOCK_W-1:0] shock_sel;
   logic [SHOCK_W-1:0] shock_abs;
   logic [Z_W-1:0]     z_abs;
   logic               z_neg;
   logic [WGT_W-1:0]   arch_eff;
   logic [WGT_W-1:0]   garch_eff;
   logic [ACC_W-1:0]   var_rounded;
   logic               var_over;
   logic [PROD_W-1:0]  mag_rounded;
   logic [MAG_W-1:0]   mag;
   logic               shock_over;
   logic [SHOCK_W-1:0] mag_clip;
   logic [SHOCK_W-1:0] shock_val;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      term_in        = term_ff;
      mac_cmd.start  = 1'b0;
      sqrt_cmd.start = 1'b0;
      finish_go      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               term_in  = '0;
               state_in = ST_SQ_START;
            end
         end
         ST_SQ_START: begin
            mac_cmd.start = 1'b1;
            state_in      = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (mac_status.done) begin
               state_in = ST_AW_START;
            end
         end
         ST_AW_START: begin
            mac_cmd.start = 1'b1;
            state_in      = ST_AW_WAIT;
         end
         ST_AW_WAIT: begin
            if (mac_status.done) begin
               if (term_ff == LAST_TERM) begin
                  term_in  = '0;
                  state_in = ST_GW_START;
               end else begin
                  term_in  = term_ff + HIST_IDX_W'(1);
                  state_in = ST_SQ_START;
               end
            end
         end
         ST_GW_START: begin
            mac_cmd.start = 1'b1;
            state_in      = ST_GW_WAIT;
         end
         ST_GW_WAIT: begin
            if (mac_status.done) begin
               if (term_ff == LAST_TERM) begin
                  term_in  = '0;
                  state_in = ST_ROUND;
               end else begin
                  term_in  = term_ff + HIST_IDX_W'(1);
                  state_in = ST_GW_START;
               end
            end
         end
         ST_ROUND: begin
            state_in = ST_SQRT_START;
         end
         ST_SQRT_START: begin
            sqrt_cmd.start = 1'b1;
            state_in       = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (sqrt_status.done) begin
               state_in = ST_SHOCK_START;
            end
         end
         ST_SHOCK_START: begin
            mac_cmd.start = 1'b1;
            state_in      = ST_SHOCK_WAIT;
         end
         ST_SHOCK_WAIT: begin
            if (mac_status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The step commits only when the output register can take a word.
            if (!rsp_valid_ff || rsp_ready) begin
               finish_go = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // ------------------------------------------------------------------
   // Operand selection for the shared multiplier
   // ------------------------------------------------------------------
   assign shock_sel = shock_hist_ff[term_ff];
   assign shock_abs = shock_sel[SHOCK_W-1] ? (~shock_sel + SHOCK_W'(1)) : shock_sel;
   assign z_neg     = z_ff[Z_W-1];
   assign z_abs     = z_neg ? (~z_ff + Z_W'(1)) : z_ff;

   // Terms above the configured order carry no weight.
   assign arch_eff  = (int'(term_ff) < ARCH_ORDER)  ? arch_w_ff[term_ff]  : '0;
   assign garch_eff = (int'(term_ff) < GARCH_ORDER) ? garch_w_ff[term_ff] : '0;

   always_comb begin
      unique case (state_ff)
         ST_SQ_START: begin
            mac_mcand  = PROD_W'(shock_abs);
            mac_mplier = MAC_W'(shock_abs);
         end
         ST_AW_START: begin
            mac_mcand  = PROD_W'(sq_ff);
            mac_mplier = MAC_W'(arch_eff);
         end
         ST_GW_START: begin
            mac_mcand  = PROD_W'({var_hist_ff[term_ff], GARCH_ALIGN'(0)});
            mac_mplier = MAC_W'(garch_eff);
         end
         ST_SHOCK_START: begin
            mac_mcand  = PROD_W'(vol_ff);
            mac_mplier = MAC_W'(z_abs);
         end
         default: begin
            mac_mcand  = '0;
            mac_mplier = '0;
         end
      endcase
   end

   gvr_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mac_cmd),
      .mcand   (mac_mcand),
      .mplier  (mac_mplier),
      .status  (mac_status),
      .product (mac_product)
   );

   gvr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .cmd      (sqrt_cmd),
      .radicand ({var_ff, VOL_SHIFT'(0)}),
      .status   (sqrt_status),
      .root     (sqrt_root)
   );

   // ------------------------------------------------------------------
   // Rounding and clipping
   // ------------------------------------------------------------------
   assign var_rounded = acc_ff + VAR_ROUND_BIAS;
   assign var_over    = |var_rounded[ACC_W-1:VAR_ROUND_SHIFT+VAR_W];

   assign mag_rounded = mac_product + SHOCK_ROUND_BIAS;
   assign mag         = mag_rounded[PROD_W-1:SHOCK_ROUND_SHIFT];

   always_comb begin
      shock_over = 1'b0;
      mag_clip   = mag[SHOCK_W-1:0];
      if (z_neg) begin
         if (mag > MAG_NEG_LIMIT) begin
            shock_over = 1'b1;
            mag_clip   = MAG_NEG_LIMIT[SHOCK_W-1:0];
         end
      end else begin
         if (mag > MAG_POS_LIMIT) begin
            shock_over = 1'b1;
            mag_clip   = MAG_POS_LIMIT[SHOCK_W-1:0];
         end
      end
   end

   assign shock_val = z_neg ? (~mag_clip + SHOCK_W'(1)) : mag_clip;

   // ------------------------------------------------------------------
   // Working registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         z_ff   <= $unsigned(req_innovation);
         acc_ff <= ACC_W'(base_variance_ff) << VAR_ROUND_SHIFT;
      end
      if (state_ff == ST_SQ_WAIT && mac_status.done) begin
         sq_ff <= mac_product[SQ_W-1:0];
      end
      if ((state_ff == ST_AW_WAIT || state_ff == ST_GW_WAIT) && mac_status.done) begin
         acc_ff <= acc_ff + ACC_W'(mac_product);
      end
      if (state_ff == ST_ROUND) begin
         var_ff <= var_over ? VAR_MAX : var_rounded[VAR_ROUND_SHIFT +: VAR_W];
         sat_ff <= var_over;
      end
      if (state_ff == ST_SQRT_WAIT && sqrt_status.done) begin
         vol_ff <= sqrt_root;
      end
      if (state_ff == ST_SHOCK_WAIT && mac_status.done) begin
         shock_ff <= shock_val;
         sat_ff   <= sat_ff | shock_over;
      end
   end

   // ------------------------------------------------------------------
   // Configuration, history and warm-up
   // ------------------------------------------------------------------
   assign suppress     = (warmup_done_ff < warmup_count_ff);
   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (finish_go && !suppress);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_variance_ff <= BASE_VARIANCE_RESET;
         warmup_count_ff  <= '0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            arch_w_ff[i]     <= '0;
            garch_w_ff[i]    <= '0;
            shock_hist_ff[i] <= '0;
            var_hist_ff[i]   <= VAR_ONE;
         end
         warmup_done_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_BASE_VARIANCE:  base_variance_ff <= csr_write_data[VAR_W-1:0];
               CSR_WARMUP_COUNT:   warmup_count_ff  <= csr_write_data[WARM_W-1:0];
               CSR_ARCH_WEIGHT_1:  arch_w_ff[0]     <= csr_write_data[WGT_W-1:0];
               CSR_ARCH_WEIGHT_2:  arch_w_ff[1]     <= csr_write_data[WGT_W-1:0];
               CSR_ARCH_WEIGHT_3:  arch_w_ff[2]     <= csr_write_data[WGT_W-1:0];
               CSR_GARCH_WEIGHT_1: garch_w_ff[0]    <= csr_write_data[WGT_W-1:0];
               CSR_GARCH_WEIGHT_2: garch_w_ff[1]    <= csr_write_data[WGT_W-1:0];
               CSR_GARCH_WEIGHT_3: garch_w_ff[2]    <= csr_write_data[WGT_W-1:0];
               default: begin
               end
            endcase
         end
         if (finish_go) begin
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
               shock_hist_ff[i] <= shock_hist_ff[i-1];
               var_hist_ff[i]   <= var_hist_ff[i-1];
            end
            shock_hist_ff[0] <= shock_ff;
            var_hist_ff[0]   <= var_ff;
            if (suppress) begin
               warmup_done_ff <= warmup_done_ff + WARM_W'(1);
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go && !suppress) begin
         rsp_shock_ff     <= shock_ff;
         rsp_variance_ff  <= var_ff;
         rsp_saturated_ff <= sat_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_shock     = $signed(rsp_shock_ff);
   assign rsp_variance  = rsp_variance_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule

`default_nettype wire

/* design/gvr_checker.sv */
// ----------------------------------------------------------------------------
// GVR port checker
// Watches the ports of the volatility recursion for ordering slips and for a nonzero shock at zero variance.
// ----------------------------------------------------------------------------
`default_nettype none

module gvr_assertions import gvr_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic signed [Z_W-1:0]     req_innovation,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [SHOCK_W-1:0] rsp_shock,
   input logic [VAR_W-1:0]          rsp_variance,
   input logic                      rsp_saturated,
   input logic                      csr_write_enable,
   input logic [CSR_IDX_W-1:0]      csr_index,
   input logic [CSR_DATA_W-1:0]     csr_write_data
);

   // A held result word must not change under back-pressure.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_shock) && $stable(rsp_variance) && $stable(rsp_saturated))
      else $error("result word changed while stalled");

   // Once a word is taken, the block is busy on it in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a word was taken");

   // A new result only appears right after the block was busy on a word.
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a step in progress");

   // Zero variance means zero volatility and therefore zero shock.
   a_zero_variance_shock: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_variance == '0 |-> rsp_shock == '0)
      else $error("nonzero shock with zero variance");

endmodule

bind garch_volatility_recursion gvr_assertions u_gvr_checker (.*);

`default_nettype wire
